FILE: design/tmse_pkg.sv
// Shared types and constants of the Turing machine step engine.
package tmse_pkg;

	localparam int SYM_W      = 2;
	localparam int STATE_W    = 4;
	localparam int POS_W      = 10;
	localparam int MOVE_W     = 2;
	localparam int NSTATES_W  = 5;
	localparam int NSYMS_W    = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [NSTATES_W-1:0] NSTATES_RST = 5'd16;
	localparam logic [NSYMS_W-1:0]   NSYMS_RST   = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STATES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS = 2'd1;

	// Head moves held in a rule
	localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'd0;
	localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd1;
	localparam logic [MOVE_W-1:0] MOVE_HALT  = 2'd2;

	typedef enum logic [1:0] {
		MODE_LOAD = 2'd0,
		MODE_TAPE = 2'd1,
		MODE_SET  = 2'd2,
		MODE_STEP = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_HALT = 2'd1,
		ST_BAD  = 2'd2,
		ST_EDGE = 2'd3
	} status_t;

	// What every tape cell does at the next edge
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_LOAD = 2'd1,
		CELL_DOWN = 2'd2,
		CELL_UP   = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic              wr0;
		logic [SYM_W-1:0]  wdat;
	} cell_ctl_t;

	typedef struct packed {
		logic [STATE_W-1:0] next;
		logic [SYM_W-1:0]   sym;
		logic [MOVE_W-1:0]  move;
	} rule_t;

	localparam rule_t RULE_HALT = '{next: '0, sym: '0, move: MOVE_HALT};

endpackage

FILE: design/tmse_cell.sv
// One tape cell: holds a symbol, loads it, or takes a neighbour's symbol.
module tmse_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tmse_pkg::cell_ctl_t        ctl,
	input  logic                       sel,
	input  logic [tmse_pkg::SYM_W-1:0] from_dn,
	input  logic [tmse_pkg::SYM_W-1:0] from_up,
	output logic [tmse_pkg::SYM_W-1:0] sym_q
);
	import tmse_pkg::*;

	// Load, shift or hold the symbol
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q <= '0;
		end else begin
			case (ctl.op)
				CELL_LOAD: begin
					if (sel) begin
						sym_q <= ctl.wdat;
					end
				end
				CELL_DOWN: sym_q <= from_dn;
				CELL_UP:   sym_q <= from_up;
				default:   sym_q <= sym_q;
			endcase
		end
	end

endmodule

FILE: design/tmse_tape.sv
// Tape ring: cell k holds the tape cell at (k + head) mod TAPE_CELLS.
module tmse_tape #(
	parameter int TAPE_CELLS = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tmse_pkg::cell_ctl_t             ctl,
	input  logic [$clog2(TAPE_CELLS)-1:0]   sel_off,
	output logic [tmse_pkg::SYM_W-1:0]      head_sym
);
	import tmse_pkg::*;

	localparam int AW = $clog2(TAPE_CELLS);

	logic [SYM_W-1:0] cell_sym [TAPE_CELLS];
	logic [SYM_W-1:0] src      [TAPE_CELLS];

	// Cell zero sits under the head
	assign head_sym = cell_sym[0];

	for (genvar k = 0; k < TAPE_CELLS; k++) begin : g_cell
		// Head cell hands on the freshly written symbol when shifting
		if (k == 0) begin : g_head
			assign src[k] = ctl.wr0 ? ctl.wdat : cell_sym[k];
		end else begin : g_body
			assign src[k] = cell_sym[k];
		end

		tmse_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.sel     (sel_off == AW'(k)),
			.from_dn (src[(k + 1) % TAPE_CELLS]),
			.from_up (src[(k + TAPE_CELLS - 1) % TAPE_CELLS]),
			.sym_q   (cell_sym[k])
		);
	end

endmodule

FILE: design/tmse_rules.sv
// Transition table memory with per-entry valid bits; unloaded entries read as halt.
module tmse_rules #(
	parameter int ROWS = 16,
	parameter int SYMS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [$clog2(ROWS*SYMS)-1:0]    wr_addr,
	input  tmse_pkg::rule_t                 wr_rule,
	input  logic                            rd_en,
	input  logic                            rd_hit,
	input  logic [$clog2(ROWS*SYMS)-1:0]    rd_addr,
	output tmse_pkg::rule_t                 rd_rule
);
	import tmse_pkg::*;

	localparam int DEPTH = ROWS * SYMS;

	rule_t            mem [DEPTH];
	rule_t            rd_q;
	logic [DEPTH-1:0] valid_q;
	logic             ok_q;

	// Write and read the table
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_rule;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Track loaded entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ok_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				ok_q <= rd_hit && valid_q[rd_addr];
			end
		end
	end

	assign rd_rule = ok_q ? rd_q : RULE_HALT;

endmodule

FILE: design/turing_machine_step_engine_core.sv
// Top level of the Turing machine step engine: command decode, head control and results.
//
// Usage:
//   Raise start with mode and its operands; the item is taken at an edge where busy is
//   low. Exactly one result follows, shown for one cycle with done high, together with
//   status, machine_state, head_at and symbol_written. The receiver cannot stall it.
//   How each item finishes after the accepting edge:
//     load rule, write tape cell, any rejected item : done is set at the accepting edge
//     step                                          : table read, then update in S_EXEC
//     set state and head                            : head walks to the new head in S_SEEK
//   The tape is a ring of cells that rotates one place per cycle while the head moves,
//   so that the cell under the head stays at cell zero; a head move costs one rotation,
//   and setting the head walks the ring one cell per cycle. The rule table is a memory
//   read at accept. A new item may be started in the cycle that done is shown.
//   Configuration writes (cfg_valid, always ready) set states_in_use (index 0) and
//   symbols_in_use (index 1); write them only while no item is in flight.
//   Reset blanks every tape cell, marks every rule as halt, clears state and head, and
//   returns both counts to 16 and 4. No clearing pass is needed after reset.
module turing_machine_step_engine_core #(
	parameter int MAX_STATES  = 16,
	parameter int MAX_SYMBOLS = 4,
	parameter int TAPE_CELLS  = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	output logic                             done,
	input  logic [1:0]                       mode,
	input  logic [tmse_pkg::STATE_W-1:0]     state_index,
	input  logic [tmse_pkg::SYM_W-1:0]       symbol_index,
	input  logic [tmse_pkg::STATE_W-1:0]     target_state,
	input  logic [tmse_pkg::SYM_W-1:0]       new_symbol,
	input  logic [tmse_pkg::MOVE_W-1:0]      direction,
	input  logic [tmse_pkg::POS_W-1:0]       position,
	output logic [1:0]                       status,
	output logic [tmse_pkg::STATE_W-1:0]     machine_state,
	output logic [tmse_pkg::POS_W-1:0]       head_at,
	output logic [tmse_pkg::SYM_W-1:0]       symbol_written,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tmse_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tmse_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tmse_pkg::*;

	localparam int ROW_N  = (MAX_STATES < 16) ? MAX_STATES : 16;
	localparam int SYM_N  = (MAX_SYMBOLS < 4) ? MAX_SYMBOLS : 4;
	localparam int RULE_N = ROW_N * SYM_N;
	localparam int IW     = $clog2(RULE_N);
	localparam int HW     = $clog2(TAPE_CELLS);
	localparam int CW     = (HW > POS_W) ? HW : POS_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_SEEK = 3'b100
	} fsm_t;

	fsm_t                  fsm_q;
	logic [NSTATES_W-1:0]  states_q;
	logic [NSYMS_W-1:0]    syms_q;
	logic [STATE_W-1:0]    cur_state_q;
	logic [HW-1:0]         head_q;
	logic [HW-1:0]         target_q;
	logic                  done_q;
	status_t               status_q;
	logic [SYM_W-1:0]      wsym_q;

	logic                  accept;
	mode_t                 mode_in;
	logic                  pos_ok;
	logic                  state_ok;
	logic                  sym_ok;
	logic                  load_ok;
	logic [IW-1:0]         load_addr;
	logic [SYM_W-1:0]      head_sym;
	logic                  step_hit;
	logic [IW-1:0]         step_addr;
	logic [CW:0]           off_wide;
	logic [HW-1:0]         sel_off;
	cell_ctl_t             tape_ctl;
	rule_t                 rule_e;
	rule_t                 load_rule;
	logic                  at_left;
	logic                  at_right;

	assign busy      = (fsm_q != S_IDLE);
	assign accept    = start && !busy;
	assign mode_in   = mode_t'(mode);
	assign cfg_ready = 1'b1;

	// Check operands of the incoming item
	assign pos_ok   = int'(position) < TAPE_CELLS;
	assign state_ok = ({1'b0, state_index} < states_q) && (int'(state_index) < ROW_N);
	assign sym_ok   = ({1'b0, symbol_index} < syms_q) && (int'(symbol_index) < SYM_N);
	assign load_ok  = state_ok && sym_ok;
	assign load_addr = load_ok ?
		IW'(int'(state_index) * SYM_N + int'(symbol_index)) : '0;
	assign load_rule = '{next: target_state, sym: new_symbol, move: direction};

	// Address the rule for the symbol under the head
	assign step_hit  = (int'(cur_state_q) < ROW_N) && (int'(head_sym) < SYM_N);
	assign step_addr = step_hit ?
		IW'(int'(cur_state_q) * SYM_N + int'(head_sym)) : '0;

	// Ring offset of a tape address relative to the head
	always_comb begin
		if ((CW + 1)'(position) >= (CW + 1)'(head_q)) begin
			off_wide = (CW + 1)'(position) - (CW + 1)'(head_q);
		end else begin
			off_wide = (CW + 1)'(position) + (CW + 1)'(TAPE_CELLS) - (CW + 1)'(head_q);
		end
	end

	assign at_left  = (head_q == '0);
	assign at_right = (int'(head_q) + 1 >= TAPE_CELLS);

	// Drive the tape cells
	always_comb begin
		tape_ctl = '{op: CELL_HOLD, wr0: 1'b0, wdat: '0};
		sel_off  = '0;
		unique case (fsm_q)
			S_IDLE: begin
				if (accept && mode_in == MODE_TAPE && pos_ok) begin
					tape_ctl.op   = CELL_LOAD;
					tape_ctl.wdat = new_symbol;
					sel_off       = HW'(off_wide);
				end
			end
			S_EXEC: begin
				tape_ctl.wdat = rule_e.sym;
				if (rule_e.move == MOVE_LEFT && !at_left) begin
					tape_ctl.op  = CELL_UP;
					tape_ctl.wr0 = 1'b1;
				end else if (rule_e.move == MOVE_RIGHT && !at_right) begin
					tape_ctl.op  = CELL_DOWN;
					tape_ctl.wr0 = 1'b1;
				end else begin
					tape_ctl.op = CELL_LOAD;
				end
			end
			S_SEEK: begin
				if (target_q > head_q) begin
					tape_ctl.op = CELL_DOWN;
				end else if (target_q < head_q) begin
					tape_ctl.op = CELL_UP;
				end
			end
			default: begin
				tape_ctl.op = CELL_HOLD;
			end
		endcase
	end

	tmse_tape #(
		.TAPE_CELLS (TAPE_CELLS)
	) u_tape (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (tape_ctl),
		.sel_off  (sel_off),
		.head_sym (head_sym)
	);

	tmse_rules #(
		.ROWS (ROW_N),
		.SYMS (SYM_N)
	) u_rules (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && mode_in == MODE_LOAD && load_ok),
		.wr_addr (load_addr),
		.wr_rule (load_rule),
		.rd_en   (accept && mode_in == MODE_STEP),
		.rd_hit  (step_hit),
		.rd_addr (step_addr),
		.rd_rule (rule_e)
	);

	// Sequence items, update state and head, present results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= S_IDLE;
			states_q    <= NSTATES_RST;
			syms_q      <= NSYMS_RST;
			cur_state_q <= '0;
			head_q      <= '0;
			target_q    <= '0;
			done_q      <= 1'b0;
			status_q    <= ST_OK;
			wsym_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_STATES:  states_q <= cfg_data;
					CFG_SYMBOLS: syms_q   <= cfg_data[NSYMS_W-1:0];
					default: begin
						states_q <= states_q;
					end
				endcase
			end
			unique case (fsm_q)
				S_IDLE: begin
					if (accept) begin
						wsym_q <= '0;
						unique case (mode_in)
							MODE_LOAD: begin
								status_q <= load_ok ? ST_OK : ST_BAD;
								done_q   <= 1'b1;
							end
							MODE_TAPE: begin
								status_q <= pos_ok ? ST_OK : ST_BAD;
								done_q   <= 1'b1;
							end
							MODE_SET: begin
								if (state_ok && pos_ok) begin
									cur_state_q <= state_index;
									target_q    <= HW'(position);
									status_q    <= ST_OK;
									fsm_q       <= S_SEEK;
								end else begin
									status_q <= ST_BAD;
									done_q   <= 1'b1;
								end
							end
							MODE_STEP: begin
								fsm_q <= S_EXEC;
							end
							default: begin
								fsm_q <= S_IDLE;
							end
						endcase
					end
				end
				S_EXEC: begin
					wsym_q <= rule_e.sym;
					done_q <= 1'b1;
					fsm_q  <= S_IDLE;
					if (rule_e.move == MOVE_LEFT) begin
						cur_state_q <= rule_e.next;
						if (at_left) begin
							status_q <= ST_EDGE;
						end else begin
							head_q   <= head_q - 1'b1;
							status_q <= ST_OK;
						end
					end else if (rule_e.move == MOVE_RIGHT) begin
						cur_state_q <= rule_e.next;
						if (at_right) begin
							status_q <= ST_EDGE;
						end else begin
							head_q   <= head_q + 1'b1;
							status_q <= ST_OK;
						end
					end else begin
						status_q <= ST_HALT;
					end
				end
				S_SEEK: begin
					if (target_q > head_q) begin
						head_q <= head_q + 1'b1;
					end else if (target_q < head_q) begin
						head_q <= head_q - 1'b1;
					end else begin
						done_q <= 1'b1;
						fsm_q  <= S_IDLE;
					end
				end
				default: begin
					fsm_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign machine_state  = cur_state_q;
	assign head_at        = POS_W'(head_q);
	assign symbol_written = wsym_q;

`ifndef SYNTHESIS
	a_exec_one: assert property (@(posedge clk) disable iff (!arst_n)
		fsm_q == S_EXEC |=> done && fsm_q == S_IDLE)
		else $error("step did not finish one cycle after the table read");

	a_seek_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == S_SEEK && head_q != target_q) |=> (head_q != $past(head_q)) && !done)
		else $error("head did not advance while seeking");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(head_q) < TAPE_CELLS)
		else $error("head left the tape window");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(accept) || $past(fsm_q == S_EXEC) || $past(fsm_q == S_SEEK)))
		else $error("result shown without an item behind it");
`endif

endmodule
